// File: rtl/sevseg_pkg.sv
// ----------------------------------------------------------------------------
// sevseg_pkg
// Shared types, constants and the BCD glyph decoder for the scanned
// seven-segment display controller.
// ----------------------------------------------------------------------------
package sevseg_pkg;

	localparam int DEFAULT_MAX_DIGITS = 8;
	localparam int CNT_W              = 5;
	localparam int CFG_IDX_W          = 2;
	localparam int CFG_DATA_W         = 16;
	localparam int PERIOD_W           = 16;

	localparam logic [3:0] DIGIT_COUNT_RESET = 4'd4;
	localparam logic [7:0] DOT_BIT           = 8'h80;

	localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_COUNT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FLASH_FIRST  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FLASH_LAST   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FLASH_PERIOD = 2'd3;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_DIGIT = 2'd1,
		OP_DOTS  = 2'd2,
		OP_DOT   = 2'd3
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [2:0] pos;
		logic [2:0] last;
		logic [7:0] glyph;
		logic       clear;
	} cmd_t;

	function automatic logic [7:0] bcd_glyph(input logic [3:0] value);
		logic [7:0] g;
		case (value)
			4'd0:    g = 8'h3F;
			4'd1:    g = 8'h06;
			4'd2:    g = 8'h5B;
			4'd3:    g = 8'h4F;
			4'd4:    g = 8'h66;
			4'd5:    g = 8'h6D;
			4'd6:    g = 8'h7D;
			4'd7:    g = 8'h07;
			4'd8:    g = 8'h7F;
			4'd9:    g = 8'h6F;
			default: g = 8'h00;
		endcase
		return g;
	endfunction

endpackage

// File: rtl/sevseg_front.sv
// ----------------------------------------------------------------------------
// sevseg_front
// Classify an incoming item into a command: operation, positions, the
// decoded glyph for digit writes and the clear-all request.
// ----------------------------------------------------------------------------
module sevseg_front (
	input  logic [1:0]          mode,
	input  logic [2:0]          digit_position,
	input  logic [2:0]          range_last,
	input  logic [3:0]          bcd_value,
	input  logic                starts_number,
	output sevseg_pkg::cmd_t    cmd
);

	always_comb begin
		cmd.op    = sevseg_pkg::op_t'(mode);
		cmd.pos   = digit_position;
		cmd.last  = range_last;
		cmd.glyph = sevseg_pkg::bcd_glyph(bcd_value);
		cmd.clear = (sevseg_pkg::op_t'(mode) == sevseg_pkg::OP_DIGIT) && starts_number;
	end

endmodule

// File: rtl/sevseg_queue.sv
// ----------------------------------------------------------------------------
// sevseg_queue
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
module sevseg_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  sevseg_pkg::cmd_t push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output sevseg_pkg::cmd_t pop_data
);

	sevseg_pkg::cmd_t entry_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("queue count overflow");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q))
		else $error("queue pointers disagree with count");

endmodule

// File: rtl/sevseg_back.sv
// ----------------------------------------------------------------------------
// sevseg_back
// Execute commands on the pattern store, scan position and flash counter;
// hold configuration and the registered result.
// ----------------------------------------------------------------------------
module sevseg_back #(
	parameter int MAX_DIGITS = sevseg_pkg::DEFAULT_MAX_DIGITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cmd_valid,
	output logic                                cmd_ready,
	input  sevseg_pkg::cmd_t                    cmd,
	input  logic                                cfg_write,
	input  logic [sevseg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sevseg_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [7:0]                          segment_pattern,
	output logic [2:0]                          digit_select
);

	localparam int ADW     = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam int RESET_N = (MAX_DIGITS < 4) ? MAX_DIGITS : 4;
	localparam logic [ADW-1:0] ACTIVE_RESET = ADW'(RESET_N - 1);
	localparam logic [sevseg_pkg::CNT_W-1:0] MAX_N = sevseg_pkg::CNT_W'(MAX_DIGITS);

	logic [7:0]                        store_q [MAX_DIGITS];
	logic [7:0]                        store_d [MAX_DIGITS];
	logic [ADW-1:0]                    active_q;
	logic [ADW-1:0]                    active_d;
	logic [ADW-1:0]                    tick_next;
	logic [sevseg_pkg::PERIOD_W-1:0]   flash_cnt_q;
	logic [sevseg_pkg::PERIOD_W-1:0]   flash_cnt_d;
	logic [sevseg_pkg::PERIOD_W-1:0]   cnt_inc;
	logic [3:0]                        digit_count_q;
	logic [2:0]                        flash_first_q;
	logic [2:0]                        flash_last_q;
	logic [sevseg_pkg::PERIOD_W-1:0]   flash_period_q;
	logic [sevseg_pkg::CNT_W-1:0]      cnt5;
	logic [sevseg_pkg::CNT_W-1:0]      n5;
	logic [sevseg_pkg::CNT_W-1:0]      inc5;
	logic [sevseg_pkg::CNT_W-1:0]      cfg_n5;
	logic                              take;
	logic                              take_tick;
	logic                              blank;
	logic                              in_flash;
	logic                              out_valid_q;
	logic [7:0]                        seg_q;
	logic [2:0]                        sel_q;
	logic [7:0]                        seg_d;

	assign cnt5      = {1'b0, digit_count_q};
	assign n5        = (cnt5 == '0) ? sevseg_pkg::CNT_W'(1) : ((cnt5 > MAX_N) ? MAX_N : cnt5);
	assign cfg_n5    = ({1'b0, cfg_data[3:0]} == '0) ? sevseg_pkg::CNT_W'(1) :
		(({1'b0, cfg_data[3:0]} > MAX_N) ? MAX_N : {1'b0, cfg_data[3:0]});
	assign inc5      = sevseg_pkg::CNT_W'(active_q) + sevseg_pkg::CNT_W'(1);
	assign tick_next = (inc5 == n5) ? '0 : ADW'(inc5);
	assign cnt_inc   = flash_cnt_q + sevseg_pkg::PERIOD_W'(1);

	assign cmd_ready = (cmd.op != sevseg_pkg::OP_TICK) || !out_valid_q || out_ready;
	assign take      = cmd_valid && cmd_ready;
	assign take_tick = take && (cmd.op == sevseg_pkg::OP_TICK);

	assign in_flash = (sevseg_pkg::CNT_W'(tick_next) >= {2'b00, flash_first_q}) &&
		(sevseg_pkg::CNT_W'(tick_next) <= {2'b00, flash_last_q});

	always_comb begin
		store_d     = store_q;
		active_d    = active_q;
		flash_cnt_d = flash_cnt_q;
		blank       = 1'b0;
		if (flash_period_q != '0 && tick_next == '0) begin
			flash_cnt_d = (cnt_inc == flash_period_q) ? '0 : cnt_inc;
		end
		if (flash_period_q != '0 && in_flash && flash_cnt_d > (flash_period_q >> 1)) begin
			blank = 1'b1;
		end
		seg_d = blank ? 8'h00 : store_q[tick_next];
		if (!take_tick) begin
			flash_cnt_d = flash_cnt_q;
		end
		if (take) begin
			case (cmd.op)
				sevseg_pkg::OP_TICK: begin
					active_d = tick_next;
				end
				sevseg_pkg::OP_DIGIT: begin
					for (int p = 0; p < MAX_DIGITS; p++) begin
						if (cmd.clear) begin
							store_d[p] = 8'h00;
						end
						if (sevseg_pkg::CNT_W'(p) == {2'b00, cmd.pos} &&
							{2'b00, cmd.pos} < n5) begin
							store_d[p] = cmd.glyph;
						end
					end
				end
				sevseg_pkg::OP_DOTS: begin
					for (int p = 0; p < MAX_DIGITS; p++) begin
						if (sevseg_pkg::CNT_W'(p) >= {2'b00, cmd.pos} &&
							sevseg_pkg::CNT_W'(p) <= {2'b00, cmd.last}) begin
							store_d[p] = store_q[p] ^ sevseg_pkg::DOT_BIT;
						end
					end
				end
				sevseg_pkg::OP_DOT: begin
					for (int p = 0; p < MAX_DIGITS; p++) begin
						if (sevseg_pkg::CNT_W'(p) == {2'b00, cmd.pos}) begin
							store_d[p] = store_q[p] | sevseg_pkg::DOT_BIT;
						end
					end
				end
				default: begin
					active_d = active_q;
				end
			endcase
		end
		if (cfg_write) begin
			case (cfg_index)
				sevseg_pkg::CFG_DIGIT_COUNT: begin
					active_d = ADW'(cfg_n5 - sevseg_pkg::CNT_W'(1));
				end
				default: begin
					flash_cnt_d = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < MAX_DIGITS; p++) begin
				store_q[p] <= 8'h00;
			end
			active_q       <= ACTIVE_RESET;
			flash_cnt_q    <= '0;
			digit_count_q  <= sevseg_pkg::DIGIT_COUNT_RESET;
			flash_first_q  <= 3'd0;
			flash_last_q   <= 3'd0;
			flash_period_q <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			store_q     <= store_d;
			active_q    <= active_d;
			flash_cnt_q <= flash_cnt_d;
			if (take_tick) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_write) begin
				case (cfg_index)
					sevseg_pkg::CFG_DIGIT_COUNT: begin
						digit_count_q <= cfg_data[3:0];
					end
					sevseg_pkg::CFG_FLASH_FIRST: begin
						flash_first_q <= cfg_data[2:0];
					end
					sevseg_pkg::CFG_FLASH_LAST: begin
						flash_last_q <= cfg_data[2:0];
					end
					sevseg_pkg::CFG_FLASH_PERIOD: begin
						flash_period_q <= cfg_data;
					end
					default: begin
						digit_count_q <= digit_count_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_tick) begin
			seg_q <= seg_d;
			sel_q <= 3'(tick_next);
		end
	end

	assign out_valid       = out_valid_q;
	assign segment_pattern = seg_q;
	assign digit_select    = sel_q;

	a_active_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		sevseg_pkg::CNT_W'(active_q) < n5)
		else $error("active digit beyond scanned digits");

	a_flash_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(flash_period_q == '0) ? (flash_cnt_q == '0) : (flash_cnt_q < flash_period_q))
		else $error("flash counter out of range");

	a_tick_result: assert property (@(posedge clk) disable iff (!arst_n)
		take_tick |=> (out_valid_q && sel_q == 3'(active_q)))
		else $error("tick result does not match scan position");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !take_tick)
		else $error("result overwritten while stalled");

endmodule

// File: rtl/seven_segment_scan_with_flash_unit.sv
// ----------------------------------------------------------------------------
// seven_segment_scan_with_flash_unit
// Scanned seven-segment display controller with digit flashing.
//
// Input channel (in_valid/in_ready) takes one command item per cycle while
// in_ready is high: a refresh tick, a BCD digit write, a dot range toggle
// or a single dot set. Only a refresh tick yields a result item on the
// output channel (out_valid/out_ready): the segment pattern and index of the
// digit to drive. A front part decodes each item into a command and pushes it
// into a two-entry queue; the back part pops one command per cycle unless a
// tick waits behind a stalled result, and updates the pattern store, scan
// position and flash counter. Throughput: one item per cycle while the output
// is taken; a stalled result is held in the output register, non-tick
// commands keep flowing, and the queue fills only when a further tick waits
// behind the stalled result. Configuration is a plain write port (cfg_write,
// cfg_index, cfg_data), to be written only while idle, which the block does
// not enforce. Reset clears all patterns, the flash counter and the queue,
// loads a digit count of four and points at the last digit.
// ----------------------------------------------------------------------------
module seven_segment_scan_with_flash_unit #(
	parameter int MAX_DIGITS = sevseg_pkg::DEFAULT_MAX_DIGITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        mode,
	input  logic [2:0]                        digit_position,
	input  logic [2:0]                        range_last,
	input  logic [3:0]                        bcd_value,
	input  logic                              starts_number,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [7:0]                        segment_pattern,
	output logic [2:0]                        digit_select,
	input  logic                              cfg_write,
	input  logic [sevseg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sevseg_pkg::CFG_DATA_W-1:0] cfg_data
);

	sevseg_pkg::cmd_t front_cmd;
	sevseg_pkg::cmd_t back_cmd;
	logic             back_valid;
	logic             back_ready;

	sevseg_front u_front (
		.mode           (mode),
		.digit_position (digit_position),
		.range_last     (range_last),
		.bcd_value      (bcd_value),
		.starts_number  (starts_number),
		.cmd            (front_cmd)
	);

	sevseg_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (in_valid),
		.push_ready (in_ready),
		.push_data  (front_cmd),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_data   (back_cmd)
	);

	sevseg_back #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd_valid       (back_valid),
		.cmd_ready       (back_ready),
		.cmd             (back_cmd),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.segment_pattern (segment_pattern),
		.digit_select    (digit_select)
	);

endmodule

// File: sim/tb_seven_segment_scan_with_flash_unit.sv
// ----------------------------------------------------------------------------
// tb_seven_segment_scan_with_flash_unit
// Self-checking bench for the scanned seven-segment controller. A short table
// of commands exercises blank and out-of-range BCD digits, clears, dot toggles
// and dot sets. Random command streams then run under several digit counts and
// flash ranges and periods. Every refresh tick is predicted by a local model of
// the pattern store, scan position and flash counter or its table row, and is
// compared with the result item. Channels stall at random except in steady runs.
// ----------------------------------------------------------------------------
module tb_seven_segment_scan_with_flash_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import sevseg_pkg::*;

	localparam int STORE_DEPTH  = DEFAULT_MAX_DIGITS;
	localparam int RANDOM_ITEMS = 155;
	localparam int SETTLE       = 8;

	typedef struct packed {
		logic [7:0] seg;
		logic [2:0] sel;
	} scan_out_t;

	typedef struct packed {
		op_t        op;
		logic [2:0] pos;
		logic [2:0] last;
		logic [3:0] bcd;
		logic       clear;
		logic       typed;
		logic [7:0] seg;
		logic [2:0] sel;
	} cmd_row_t;

	typedef struct packed {
		logic [3:0]  count;
		logic [2:0]  first;
		logic [2:0]  last;
		logic [15:0] period;
		logic        steady;
	} setting_t;

	localparam logic [7:0] GLYPH [10] = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66,
		8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F};

	localparam int NUM_ROWS = 24;
	localparam cmd_row_t DIRECTED [NUM_ROWS] = '{
		'{OP_TICK,  3'd0, 3'd0, 4'd0,  1'b0, 1'b1, 8'h00, 3'd0},
		'{OP_DIGIT, 3'd1, 3'd0, 4'd8,  1'b1, 1'b0, 8'h00, 3'd0},
		'{OP_TICK,  3'd0, 3'd0, 4'd0,  1'b0, 1'b1, 8'h7F, 3'd1},
		'{OP_DIGIT, 3'd2, 3'd0, 4'd15, 1'b0, 1'b0, 8'h00, 3'd0},
		'{OP_DIGIT, 3'd7, 3'd0, 4'd3,  1'b0, 1'b0, 8'h00, 3'd0},
		'{OP_DIGIT, 3'd3, 3'd0, 4'd0,  1'b0, 1'b0, 8'h00, 3'd0},
		'{OP_DOT,   3'd2, 3'd0, 4'd0,  1'b0, 1'b0, 8'h00, 3'd0},
		'{OP_TICK,  3'd0, 3'd0, 4'd0,  1'b0, 1'b1, 8'h80, 3'd2},
		'{OP_TICK,  3'd0, 3'd0, 4'd0,  1'b0, 1'b1, 8'h3F, 3'd3},
		'{OP_DOTS,  3'd0, 3'd7, 4'd0,  1'b0, 1'b0, 8'h00, 3'd0},
		'{OP_TICK,  3'd0, 3'd0, 4'd0,  1'b0, 1'b0, 8'h00, 3'd0},
		'{OP_DOTS,  3'd5, 3'd2, 4'd0,  1'b0, 1'b0, 8'h00, 3'd0},
		'{OP_TICK,  3'd0, 3'd0, 4'd0,  1'b0, 1'b0, 8'h00, 3'd0},
		'{OP_DIGIT, 3'd0, 3'd0, 4'd9,  1'b1, 1'b0, 8'h00, 3'd0},
		'{OP_DOT,   3'd7, 3'd0, 4'd0,  1'b0, 1'b0, 8'h00, 3'd0},
		'{OP_DIGIT, 3'd6, 3'd0, 4'd4,  1'b1, 1'b0, 8'h00, 3'd0},
		'{OP_TICK,  3'd0, 3'd0, 4'd0,  1'b0, 1'b1, 8'h00, 3'd2},
		'{OP_DIGIT, 3'd3, 3'd0, 4'd7,  1'b0, 1'b0, 8'h00, 3'd0},
		'{OP_DOT,   3'd3, 3'd0, 4'd0,  1'b0, 1'b0, 8'h00, 3'd0},
		'{OP_TICK,  3'd0, 3'd0, 4'd0,  1'b0, 1'b0, 8'h00, 3'd0},
		'{OP_TICK,  3'd0, 3'd0, 4'd0,  1'b0, 1'b0, 8'h00, 3'd0},
		'{OP_DOTS,  3'd7, 3'd7, 4'd0,  1'b0, 1'b0, 8'h00, 3'd0},
		'{OP_DIGIT, 3'd1, 3'd0, 4'd2,  1'b0, 1'b0, 8'h00, 3'd0},
		'{OP_TICK,  3'd0, 3'd0, 4'd0,  1'b0, 1'b0, 8'h00, 3'd0}
	};

	localparam int NUM_SETTINGS = 8;
	localparam setting_t SETTINGS_LIST [NUM_SETTINGS] = '{
		'{4'd8,  3'd0, 3'd7, 16'd2,     1'b0},
		'{4'd1,  3'd0, 3'd0, 16'd1,     1'b0},
		'{4'd0,  3'd3, 3'd5, 16'd3,     1'b0},
		'{4'd15, 3'd2, 3'd6, 16'd4,     1'b1},
		'{4'd5,  3'd6, 3'd2, 16'd5,     1'b0},
		'{4'd8,  3'd7, 3'd7, 16'd65535, 1'b0},
		'{4'd3,  3'd0, 3'd2, 16'd0,     1'b0},
		'{4'd7,  3'd1, 3'd4, 16'd7,     1'b0}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [1:0] mode;
	logic [2:0] digit_position;
	logic [2:0] range_last;
	logic [3:0] bcd_value;
	logic starts_number;
	logic out_valid;
	logic out_ready;
	logic [7:0] segment_pattern;
	logic [2:0] digit_select;
	logic cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	logic [7:0] disp_store [STORE_DEPTH];
	int unsigned scan_pos;
	int unsigned flash_cnt;
	int unsigned reg_count;
	int unsigned reg_first;
	int unsigned reg_last;
	int unsigned reg_period;

	scan_out_t scan_results [$];
	bit steady;
	int failures;
	int items_sent;
	int results_checked;
	int blanked_ticks;

	seven_segment_scan_with_flash_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.mode           (mode),
		.digit_position (digit_position),
		.range_last     (range_last),
		.bcd_value      (bcd_value),
		.starts_number  (starts_number),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.segment_pattern(segment_pattern),
		.digit_select   (digit_select),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int unsigned live_digits();
		if (reg_count < 1)
			return 1;
		if (reg_count > STORE_DEPTH)
			return STORE_DEPTH;
		return reg_count;
	endfunction

	function automatic void apply_command(input op_t op, input int unsigned pos,
			input int unsigned last, input int unsigned bcd, input logic clear,
			input logic typed, input scan_out_t typed_out);
		scan_out_t got;
		int unsigned n;
		n = live_digits();
		case (op)
			OP_TICK: begin
				scan_pos = (scan_pos + 1) % n;
				got.seg = disp_store[scan_pos];
				got.sel = scan_pos[2:0];
				if (reg_period != 0) begin
					if (scan_pos == 0)
						flash_cnt = (flash_cnt + 1) % reg_period;
					if (scan_pos >= reg_first && scan_pos <= reg_last &&
							flash_cnt > reg_period / 2) begin
						got.seg = 8'h00;
						blanked_ticks++;
					end
				end
				scan_results.push_back(typed ? typed_out : got);
			end
			OP_DIGIT: begin
				if (clear)
					foreach (disp_store[i])
						disp_store[i] = 8'h00;
				if (pos < n)
					disp_store[pos] = (bcd <= 9) ? GLYPH[bcd] : 8'h00;
			end
			OP_DOTS: begin
				for (int unsigned p = pos; p <= last && p < STORE_DEPTH; p++)
					disp_store[p] ^= DOT_BIT;
			end
			default: begin
				if (pos < STORE_DEPTH)
					disp_store[pos] |= DOT_BIT;
			end
		endcase
	endfunction

	task automatic send_cmd(input op_t op, input logic [2:0] pos, input logic [2:0] last,
			input logic [3:0] bcd, input logic clear, input logic typed,
			input scan_out_t typed_out);
		@(negedge clk);
		if (!steady && $urandom_range(99) < 30) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid = 1'b1;
		mode = op;
		digit_position = pos;
		range_last = last;
		bcd_value = bcd;
		starts_number = clear;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		apply_command(op, pos, last, bcd, clear, typed, typed_out);
		items_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (scan_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_write = 1'b0;
		case (idx)
			CFG_DIGIT_COUNT: begin
				reg_count = val[3:0];
				scan_pos = live_digits() - 1;
			end
			CFG_FLASH_FIRST: begin
				reg_first = val[2:0];
				flash_cnt = 0;
			end
			CFG_FLASH_LAST: begin
				reg_last = val[2:0];
				flash_cnt = 0;
			end
			default: begin
				reg_period = val;
				flash_cnt = 0;
			end
		endcase
	endtask

	task automatic send_random();
		op_t op;
		int r;
		r = $urandom_range(99);
		if (r < 50)
			op = OP_TICK;
		else if (r < 70)
			op = OP_DIGIT;
		else if (r < 85)
			op = OP_DOTS;
		else
			op = OP_DOT;
		send_cmd(op, 3'($urandom_range(7)), 3'($urandom_range(7)),
			4'($urandom_range(15)), 1'($urandom_range(99) < 10), 1'b0, '0);
	endtask

	always @(negedge clk) begin
		out_ready = steady ? 1'b1 : ($urandom_range(99) >= 30);
	end

	always @(posedge clk) begin : check_results
		scan_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (scan_results.size() == 0) begin
				$display("%0t: result with none pending, actual pattern %h digit %0d",
					$time, segment_pattern, digit_select);
				failures++;
			end else begin
				want = scan_results.pop_front();
				results_checked++;
				if (segment_pattern !== want.seg) begin
					$display("%0t: segment_pattern expected %h actual %h",
						$time, want.seg, segment_pattern);
					failures++;
				end
				if (digit_select !== want.sel) begin
					$display("%0t: digit_select expected %0d actual %0d",
						$time, want.sel, digit_select);
					failures++;
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("tb_seven_segment_scan_with_flash_unit failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = OP_TICK;
		digit_position = '0;
		range_last = '0;
		bcd_value = '0;
		starts_number = 1'b0;
		out_ready = 1'b0;
		cfg_write = 1'b0;
		cfg_index = CFG_DIGIT_COUNT;
		cfg_data = '0;
		steady = 1'b0;
		failures = 0;
		items_sent = 0;
		results_checked = 0;
		blanked_ticks = 0;

		foreach (disp_store[i])
			disp_store[i] = 8'h00;
		reg_count = DIGIT_COUNT_RESET;
		reg_first = 0;
		reg_last = 0;
		reg_period = 0;
		flash_cnt = 0;
		scan_pos = live_digits() - 1;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < NUM_ROWS; i++)
			send_cmd(DIRECTED[i].op, DIRECTED[i].pos, DIRECTED[i].last, DIRECTED[i].bcd,
				DIRECTED[i].clear, DIRECTED[i].typed, {DIRECTED[i].seg, DIRECTED[i].sel});
		drain();

		for (int s = 0; s < NUM_SETTINGS; s++) begin
			write_reg(CFG_DIGIT_COUNT, 16'(SETTINGS_LIST[s].count));
			write_reg(CFG_FLASH_FIRST, 16'(SETTINGS_LIST[s].first));
			write_reg(CFG_FLASH_LAST, 16'(SETTINGS_LIST[s].last));
			write_reg(CFG_FLASH_PERIOD, SETTINGS_LIST[s].period);
			steady = SETTINGS_LIST[s].steady;
			for (int k = 0; k < RANDOM_ITEMS; k++) begin
				if (s == 2 && k == RANDOM_ITEMS / 2)
					drain();
				send_random();
			end
			drain();
			steady = 1'b0;
		end

		$display("Sent %0d items over %0d register settings; checked %0d scan results",
			items_sent, NUM_SETTINGS + 1, results_checked);
		$display("%0d of those results fell in a flash blanking window", blanked_ticks);
		if (failures == 0)
			$display("tb_seven_segment_scan_with_flash_unit passed");
		else
			$display("tb_seven_segment_scan_with_flash_unit failed");
		$finish;
	end

endmodule

// File: seven_segment_scan_with_flash_unit.f
rtl/sevseg_pkg.sv
rtl/sevseg_front.sv
rtl/sevseg_queue.sv
rtl/sevseg_back.sv
rtl/seven_segment_scan_with_flash_unit.sv
sim/tb_seven_segment_scan_with_flash_unit.sv
